// File: hdl/npmac_pkg.sv
// ----------------------------------------------------------------------------
// npmac_pkg
// Shared types, constants and helper functions for the negacyclic polynomial
// multiply-accumulate block over Z_q[x]/(x^4+1).
// ----------------------------------------------------------------------------
package npmac_pkg;

    localparam int unsigned TK_Q    = 97;
    localparam int unsigned COEFFS  = 4;
    localparam int unsigned CW      = 7;
    localparam int unsigned BITS_W  = COEFFS;
    localparam int unsigned QUARTER = TK_Q / 4;
    localparam int unsigned HALF    = TK_Q / 2;

    // Widest dot product of one lane: COEFFS products of two reduced values.
    localparam int unsigned SUM_MAX = COEFFS * (TK_Q - 1) * (TK_Q - 1);
    localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
    localparam int unsigned QT_W    = $clog2(SUM_MAX / TK_Q + 1);

    // Reciprocal for the constant reduction of a lane sum.
    localparam int unsigned RED_SHIFT = 22;
    localparam int unsigned RED_MULT  = (2 ** RED_SHIFT + TK_Q - 1) / TK_Q;
    localparam int unsigned MULT_W    = $clog2(RED_MULT + 1);
    localparam int unsigned RP_W      = SUM_W + MULT_W;

    typedef logic [CW-1:0]    coef_t;
    typedef coef_t            coef_vec_t [COEFFS];
    typedef logic [SUM_W-1:0] lane_sum_t;
    typedef logic [QT_W-1:0]  quot_t;

    typedef struct packed {
        logic sub_term;
        logic clear_first;
        logic last_term;
    } flags_t;

    typedef struct packed {
        logic ld_prod;
        logic ld_quot;
        logic ld_term;
        logic sub_term;
    } lane_ctrl_t;

    typedef struct packed {
        logic upd;
        logic clear_first;
        logic last_term;
    } acc_ctrl_t;

    // One conditional subtraction: valid for any x below twice the modulus.
    function automatic coef_t red_once(input logic [CW:0] x);
        logic [CW:0] d;
        begin
            d = x - (CW + 1)'(TK_Q);
            red_once = (x >= (CW + 1)'(TK_Q)) ? d[CW-1:0] : x[CW-1:0];
        end
    endfunction

    // Additive inverse of a reduced value, with zero mapping to zero.
    function automatic coef_t neg_mod(input coef_t x);
        coef_t d;
        begin
            d = CW'(TK_Q) - x;
            neg_mod = (x == '0) ? '0 : d;
        end
    endfunction

endpackage

// File: hdl/negacyclic_poly_mac_mod_q.sv
// ----------------------------------------------------------------------------
// negacyclic_poly_mac_mod_q
// Negacyclic polynomial multiply-accumulate modulo q with four parallel
// coefficient lanes and a merging accumulator stage.
// ----------------------------------------------------------------------------
// Pipeline: a last term passes the input reduce, products, quotient and term
// registers, then the accumulate step writes the result into the output register.
// Throughput: one word per cycle, set by the accumulator add in the merging
// stage; the pipeline stalls only when every stage is full.
// Reset: clears all stage valid bits, the output valid and the accumulator.
// ----------------------------------------------------------------------------
module negacyclic_poly_mac_mod_q (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // a_coeff_0..3, b_coeff_0..3
    input  logic [1:0]   s_tuser,   // subtract_term, clear_first
    input  logic         s_tlast,   // last_term
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata    // sum_coeff_0..3, message_bits
);
    import npmac_pkg::*;

    coef_t       a_red_reg [COEFFS];
    coef_t       a_neg_reg [COEFFS];
    coef_t       b_red_reg [COEFFS];
    coef_t       a_in [COEFFS];
    coef_t       b_in [COEFFS];
    coef_vec_t   op_x [COEFFS];
    coef_vec_t   op_y [COEFFS];
    coef_vec_t   term;
    flags_t      f1_reg, f2_reg, f3_reg, f4_reg, f_in;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        r1, r2, r3, r4, r5;
    logic        out_free;
    lane_ctrl_t  lane_ctrl;
    acc_ctrl_t   acc_ctrl;

    always_comb begin
        for (int i = 0; i < COEFFS; i++) begin
            a_in[i] = red_once({1'b0, s_tdata[i*CW +: CW]});
            b_in[i] = red_once({1'b0, s_tdata[(COEFFS + i)*CW +: CW]});
        end
    end

    assign f_in = '{sub_term: s_tuser[0], clear_first: s_tuser[1], last_term: s_tlast};

    // A stage can load when empty or when its occupant moves on; only a last
    // term needs room in the output register.
    assign r5 = !f4_reg.last_term || out_free;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_tready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= s_tvalid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            f1_reg <= f_in;
            for (int i = 0; i < COEFFS; i++) begin
                a_red_reg[i] <= a_in[i];
                a_neg_reg[i] <= neg_mod(a_in[i]);
                b_red_reg[i] <= b_in[i];
            end
        end
        if (r2) f2_reg <= f1_reg;
        if (r3) f3_reg <= f2_reg;
        if (r4) f4_reg <= f3_reg;
    end

    // Lane k pairs a_i with b_(k-i); products that wrap past x^3 take -a_i.
    for (genvar k = 0; k < COEFFS; k++) begin : g_map
        for (genvar i = 0; i < COEFFS; i++) begin : g_term
            assign op_x[k][i] = (i <= k) ? a_red_reg[i] : a_neg_reg[i];
            assign op_y[k][i] = b_red_reg[(k + COEFFS - i) % COEFFS];
        end
    end

    assign lane_ctrl = '{ld_prod:  r2 && v1_reg,
                         ld_quot:  r3 && v2_reg,
                         ld_term:  r4 && v3_reg,
                         sub_term: f3_reg.sub_term};

    for (genvar k = 0; k < COEFFS; k++) begin : g_lane
        npmac_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .op_x    (op_x[k]),
            .op_y    (op_y[k]),
            .term    (term[k])
        );
    end

    assign acc_ctrl = '{upd:         v4_reg && r5,
                        clear_first: f4_reg.clear_first,
                        last_term:   f4_reg.last_term};

    npmac_acc u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (acc_ctrl),
        .term     (term),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled while the pipeline has a free stage");

    a_nonlast_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !f4_reg.last_term) |-> acc_ctrl.upd)
        else $error("non-last term held in the term stage");

endmodule

// File: hdl/npmac_lane.sv
// ----------------------------------------------------------------------------
// npmac_lane
// One coefficient lane: four products summed, reduced modulo q by a
// reciprocal multiply, then optionally negated to form the signed term.
// ----------------------------------------------------------------------------
module npmac_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  npmac_pkg::lane_ctrl_t  ctrl,
    input  npmac_pkg::coef_vec_t   op_x,
    input  npmac_pkg::coef_vec_t   op_y,
    output npmac_pkg::coef_t       term
);
    import npmac_pkg::*;

    lane_sum_t         sum_reg, sum_next;
    lane_sum_t         sum3_reg;
    quot_t             quot_reg, quot_next;
    coef_t             term_reg, term_next;
    logic [RP_W-1:0]   recip_prod;
    lane_sum_t         quot_mul;
    lane_sum_t         rem_wide;
    coef_t             rem_red;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < COEFFS; i++) begin
            sum_next = sum_next + SUM_W'(op_x[i]) * SUM_W'(op_y[i]);
        end
    end

    // The quotient estimate is exact over the whole range of a lane sum.
    assign recip_prod = RP_W'(sum_reg) * RP_W'(RED_MULT);
    assign quot_next  = recip_prod[RED_SHIFT +: QT_W];

    assign quot_mul  = SUM_W'(quot_reg) * SUM_W'(TK_Q);
    assign rem_wide  = sum3_reg - quot_mul;
    assign rem_red   = red_once(rem_wide[CW:0]);
    assign term_next = ctrl.sub_term ? neg_mod(rem_red) : rem_red;

    always_ff @(posedge aclk) begin
        if (ctrl.ld_prod) begin
            sum_reg <= sum_next;
        end
        if (ctrl.ld_quot) begin
            quot_reg <= quot_next;
            sum3_reg <= sum_reg;
        end
        if (ctrl.ld_term) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

    a_term_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ld_term |=> (term_reg < CW'(TK_Q)))
        else $error("lane term not reduced modulo q");

endmodule

// File: hdl/npmac_acc.sv
// ----------------------------------------------------------------------------
// npmac_acc
// Merging stage: adds the lane terms into the accumulator, decodes message
// bits and holds the result word in the output register.
// ----------------------------------------------------------------------------
module npmac_acc (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  npmac_pkg::acc_ctrl_t   ctrl,
    input  npmac_pkg::coef_vec_t   term,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata   // sum_coeff_0..3, message_bits
);
    import npmac_pkg::*;

    coef_t              acc_reg [COEFFS];
    coef_t              acc_next [COEFFS];
    logic [BITS_W-1:0]  bits_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_tdata_reg, m_tdata_next;

    always_comb begin
        for (int i = 0; i < COEFFS; i++) begin
            acc_next[i] = red_once((CW + 1)'(ctrl.clear_first ? '0 : acc_reg[i])
                                   + (CW + 1)'(term[i]));
            // The centred magnitude exceeds q/4 exactly inside this window.
            bits_next[BITS_W-1-i] = (acc_next[i] > CW'(QUARTER)) &&
                                    (acc_next[i] < CW'(TK_Q - QUARTER));
        end
        m_tdata_next = {bits_next, acc_next[3], acc_next[2], acc_next[1], acc_next[0]};
    end

    assign out_free      = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = (ctrl.upd && ctrl.last_term) ? 1'b1
                         : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < COEFFS; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (ctrl.upd) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.upd && ctrl.last_term) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg[0] < CW'(TK_Q)) && (acc_reg[1] < CW'(TK_Q)) &&
        (acc_reg[2] < CW'(TK_Q)) && (acc_reg[3] < CW'(TK_Q)))
        else $error("accumulator coefficient not reduced");

    a_emit_matches_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.upd && ctrl.last_term) |=>
            (m_tvalid_reg && (m_tdata_reg[CW-1:0] == acc_reg[0]) &&
             (m_tdata_reg[4*CW-1:3*CW] == acc_reg[3])))
        else $error("emitted word does not match accumulator");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.upd && ctrl.last_term) |-> out_free)
        else $error("result word overwritten before it was taken");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the negacyclic polynomial multiply-accumulate block.
// A short list of hand-picked terms is followed by random term sequences under
// several sender and receiver throttling patterns and one long output stall.
// Every emitted sum word is checked against a behavioural model or typed sums.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import npmac_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 12;

    typedef struct packed {
        coef_t [COEFFS-1:0] a;
        coef_t [COEFFS-1:0] b;
        logic               sub;
        logic               clr;
        logic               last;
    } mac_term_t;

    // Same layout as m_tdata: sum_coeff_0 in the lowest bits, message bits on top.
    typedef struct packed {
        logic [BITS_W-1:0]  bits;
        coef_t [COEFFS-1:0] sum;
    } mac_result_t;

    typedef struct {
        mac_term_t   term;
        bit          typed;
        mac_result_t sums;
    } directed_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;    // a_coeff_0..3, b_coeff_0..3
    logic [1:0]  s_tuser  = '0;    // subtract_term, clear_first
    logic        s_tlast  = 1'b0;  // last_term
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // sum_coeff_0..3, message_bits

    int unsigned   acc_poly [COEFFS];
    mac_result_t   pending_sums [$];
    directed_row_t directed_rows [$];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    bit            rx_hold = 1'b0;
    int unsigned   words_sent = 0;
    int unsigned   sums_checked = 0;
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;
    event          hold_start;

    negacyclic_poly_mac_mod_q dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Updates the model accumulator with one term and returns the word it would emit.
    function automatic mac_result_t accumulate_term(input mac_term_t t);
        int unsigned ra [COEFFS];
        int unsigned rb [COEFFS];
        int unsigned prod [COEFFS];
        int unsigned part;
        int unsigned mag;
        mac_result_t r;
        r = '0;
        for (int i = 0; i < COEFFS; i++) begin
            ra[i] = t.a[i] % TK_Q;
            rb[i] = t.b[i] % TK_Q;
            prod[i] = 0;
        end
        // Powers at or above x^4 wrap round with a change of sign.
        for (int i = 0; i < COEFFS; i++) begin
            for (int j = 0; j < COEFFS; j++) begin
                if (i + j < COEFFS) begin
                    prod[i + j] = (prod[i + j] + ra[i] * rb[j]) % TK_Q;
                end else begin
                    prod[i + j - COEFFS] = (prod[i + j - COEFFS]
                                            + ((TK_Q - ra[i]) % TK_Q) * rb[j]) % TK_Q;
                end
            end
        end
        for (int i = 0; i < COEFFS; i++) begin
            part = t.sub ? (TK_Q - prod[i]) % TK_Q : prod[i];
            acc_poly[i] = ((t.clr ? 0 : acc_poly[i]) + part) % TK_Q;
            mag = (acc_poly[i] > HALF) ? TK_Q - acc_poly[i] : acc_poly[i];
            r.sum[i] = coef_t'(acc_poly[i]);
            r.bits[COEFFS - 1 - i] = (mag > QUARTER);
        end
        return r;
    endfunction

    function automatic mac_term_t mk_term(input int a0, a1, a2, a3, b0, b1, b2, b3,
                                          input bit sub, clr, last);
        mac_term_t t;
        t.a = {coef_t'(a3), coef_t'(a2), coef_t'(a1), coef_t'(a0)};
        t.b = {coef_t'(b3), coef_t'(b2), coef_t'(b1), coef_t'(b0)};
        t.sub = sub;
        t.clr = clr;
        t.last = last;
        return t;
    endfunction

    function automatic mac_result_t mk_sums(input int s0, s1, s2, s3, bits);
        mac_result_t r;
        r.sum = {coef_t'(s3), coef_t'(s2), coef_t'(s1), coef_t'(s0)};
        r.bits = bits[BITS_W-1:0];
        return r;
    endfunction

    // Mostly reduced values, with some above the modulus and some at the edges.
    function automatic coef_t pick_coef();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return coef_t'($urandom_range(0, TK_Q - 1));
        if (r < 90)
            return coef_t'($urandom_range(TK_Q, 2 ** CW - 1));
        unique case ($urandom_range(0, 2))
            0: return coef_t'(0);
            1: return coef_t'(1);
            default: return coef_t'(TK_Q - 1);
        endcase
    endfunction

    function automatic mac_term_t random_term(input bit clr, input bit last);
        mac_term_t t;
        for (int i = 0; i < COEFFS; i++) begin
            t.a[i] = pick_coef();
            t.b[i] = pick_coef();
        end
        // Now and then a plain addition through the constant polynomial one.
        if ($urandom_range(0, 9) == 0) begin
            t.a = '0;
            t.a[0] = coef_t'(1);
        end
        t.sub = 1'($urandom_range(0, 1));
        t.clr = clr;
        t.last = last;
        return t;
    endfunction

    // Entered just after a falling edge; returns just after the next falling edge
    // once the word has been taken, leaving s_tvalid high for the next call.
    task automatic offer_term(input mac_term_t t, input bit typed, input mac_result_t want);
        mac_result_t sums;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.b, t.a};
        s_tuser  <= {t.clr, t.sub};
        s_tlast  <= t.last;
        do @(posedge aclk); while (!s_tready);
        sums = accumulate_term(t);
        if (t.last)
            pending_sums.push_back(typed ? want : sums);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic run_random(input int unsigned n_words, input int unsigned idle_pct,
                              input int unsigned stall_pct, input int unsigned max_len);
        int unsigned start;
        int unsigned len;
        bit broken;
        bit clr;
        bit last;
        start = words_sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (words_sent - start < n_words) begin
            len = $urandom_range(1, max_len);
            broken = ($urandom_range(0, 99) < 15);
            for (int k = 0; k < len; k++) begin
                clr = broken ? bit'($urandom_range(0, 1)) : (k == 0);
                last = broken ? bit'($urandom_range(0, 1)) : (k == len - 1);
                offer_term(random_term(clr, last), 1'b0, '0);
            end
        end
    endtask

    always @(negedge aclk)
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);

    initial forever begin
        @(hold_start);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    always @(posedge aclk) begin
        mac_result_t got;
        mac_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_sums.size() == 0) begin
                $error("sum word %h arrived with none expected", m_tdata);
                mismatches++;
            end else begin
                want = pending_sums.pop_front();
                for (int i = 0; i < COEFFS; i++) begin
                    if (got.sum[i] !== want.sum[i]) begin
                        $error("sum_coeff_%0d: expected %0d, got %0d",
                               i, want.sum[i], got.sum[i]);
                        mismatches++;
                    end
                end
                if (got.bits !== want.bits) begin
                    $error("message_bits: expected %b, got %b", want.bits, got.bits);
                    mismatches++;
                end
                sums_checked++;
            end
        end
    end

    initial begin
        // Right after reset the accumulator must read as zero.
        directed_rows.push_back('{mk_term(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                                  mk_sums(0, 0, 0, 0, 0)});
        // Decision threshold at a quarter of q, approached from both sides.
        directed_rows.push_back('{mk_term(1, 0, 0, 0, 48, 49, 24, 25, 0, 1, 1), 1,
                                  mk_sums(48, 49, 24, 25, 4'b1101)});
        directed_rows.push_back('{mk_term(1, 0, 0, 0, 72, 73, 0, 97, 0, 1, 1), 1,
                                  mk_sums(72, 73, 0, 0, 4'b1000)});
        // Coefficients above the modulus are reduced first.
        directed_rows.push_back('{mk_term(127, 0, 0, 0, 1, 0, 0, 0, 0, 1, 1), 1,
                                  mk_sums(30, 0, 0, 0, 4'b1000)});
        directed_rows.push_back('{mk_term(97, 97, 97, 97, 5, 6, 7, 8, 0, 1, 1), 1,
                                  mk_sums(0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_term(1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1), 1,
                                  mk_sums(96, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_term(0, 0, 0, 0, 9, 9, 9, 9, 1, 1, 1), 1,
                                  mk_sums(0, 0, 0, 0, 0)});
        // x^4 and x^6 wrap round as -1 and -x^2.
        directed_rows.push_back('{mk_term(0, 1, 0, 0, 0, 0, 0, 1, 0, 1, 1), 1,
                                  mk_sums(96, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_term(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1), 1,
                                  mk_sums(0, 0, 96, 0, 0)});
        directed_rows.push_back('{mk_term(96, 0, 0, 0, 96, 0, 0, 0, 0, 1, 1), 1,
                                  mk_sums(1, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_term(96, 96, 96, 96, 96, 96, 96, 96, 0, 1, 1), 0, '0});
        directed_rows.push_back('{mk_term(127, 127, 127, 127, 127, 127, 127, 127, 0, 1, 1),
                                  0, '0});
        // A chain of terms, then a further sequence that keeps the sum.
        directed_rows.push_back('{mk_term(3, 50, 96, 12, 77, 5, 0, 96, 0, 1, 0), 0, '0});
        directed_rows.push_back('{mk_term(64, 1, 33, 90, 2, 88, 41, 7, 1, 0, 0), 0, '0});
        directed_rows.push_back('{mk_term(1, 0, 0, 0, 20, 30, 40, 50, 0, 0, 1), 0, '0});
        directed_rows.push_back('{mk_term(11, 22, 33, 44, 55, 66, 77, 88, 0, 0, 1), 0, '0});
        directed_rows.push_back('{mk_term(1, 0, 0, 0, 96, 1, 48, 49, 1, 0, 1), 0, '0});
        // Clearing again discards whatever the open sequence had gathered.
        directed_rows.push_back('{mk_term(60, 61, 62, 63, 64, 65, 66, 67, 0, 1, 0), 0, '0});
        directed_rows.push_back('{mk_term(5, 0, 0, 0, 7, 8, 9, 10, 0, 1, 1), 0, '0});
        directed_rows.push_back('{mk_term(100, 120, 97, 127, 127, 98, 64, 1, 1, 1, 1), 0, '0});
        directed_rows.push_back('{mk_term(42, 85, 17, 96, 31, 0, 127, 66, 1, 0, 0), 0, '0});
        directed_rows.push_back('{mk_term(0, 0, 1, 0, 96, 96, 0, 0, 0, 0, 1), 0, '0});

        for (int i = 0; i < COEFFS; i++)
            acc_poly[i] = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            offer_term(directed_rows[i].term, directed_rows[i].typed, directed_rows[i].sums);

        run_random(400, 0, 0, 6);
        run_random(400, 85, 0, 6);
        run_random(400, 0, 85, 6);
        run_random(400, 8, 8, 6);

        // Output held off while each offered word is a one-term sequence that closes unless drawn broken.
        ->hold_start;
        run_random(60, 0, 0, 1);

        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d terms (directed, four throttling mixes, one long output stall).",
                 words_sent);
        $display("Checked %0d accumulator words, %0d field mismatches.",
                 sums_checked, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
